### src/drrip_replacement_with_stream_bypass_assert.svh
// Assertion macros shared by the replacement policy RTL.
`ifndef DRRIP_REPLACEMENT_WITH_STREAM_BYPASS_ASSERT_SVH
`define DRRIP_REPLACEMENT_WITH_STREAM_BYPASS_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked on every rising clock edge outside reset.
`define DRRIP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on every rising clock edge, reset included.
`define DRRIP_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define DRRIP_ASSERT(name, prop, msg)
`define DRRIP_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

### src/drrip_pkg.sv
// Constants and types of the DRRIP replacement policy with stream bypass.
package drrip_pkg;

  localparam int unsigned SETS         = 2048;
  localparam int unsigned SET_W        = 11;
  localparam int unsigned WAYS         = 16;
  localparam int unsigned WAY_W        = 4;
  localparam int unsigned LEADER_SETS  = 64;
  localparam int unsigned SELECTOR_MAX = 1023;
  localparam int unsigned PSEL_W       = 10;
  localparam int unsigned ADDR_W       = 64;
  localparam int unsigned SCORE_W      = 4;
  localparam int unsigned LIMIT_W      = 17;
  localparam int unsigned CHANCE_W     = 5;

  localparam logic [1:0]         RRPV_FAR    = 2'd3;
  localparam logic [1:0]         RRPV_NEAR   = 2'd2;
  localparam logic [SCORE_W-1:0] SCORE_MAX   = 4'd15;
  localparam logic [PSEL_W-1:0]  PSEL_RESET  = PSEL_W'(SELECTOR_MAX / 2);
  localparam logic [PSEL_W-1:0]  PSEL_TOP    = PSEL_W'(SELECTOR_MAX);
  localparam logic [SCORE_W-1:0] THR_RESET   = 4'd12;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd256;

  // Register map, indexed by byte address bit 2.
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_STRIDE    = 1'b1;

  typedef enum logic {
    CMD_VICTIM = 1'b0,
    CMD_UPDATE = 1'b1
  } cmd_e;

  // One memory row holds everything kept per set.
  typedef struct packed {
    logic [ADDR_W-1:0]       hist_addr;
    logic [SCORE_W-1:0]      score;
    logic [WAYS-1:0][1:0]    rrpv;
  } row_t;

  localparam int unsigned ROW_W = $bits(row_t);

  // Reset contents of a row: all RRPVs far, no history.
  localparam row_t ROW_RESET = '{hist_addr: '0, score: '0, rrpv: {WAYS{RRPV_FAR}}};

endpackage

### src/drrip_ram.sv
// Simple dual-port synchronous RAM with registered read data.
module drrip_ram #(
  parameter int unsigned DataW = 100,
  parameter int unsigned Depth = 2048,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, with registered read data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/drrip_replacement_with_stream_bypass.sv
// Top level: DRRIP replacement policy with a per-set stream detector.
//
// Commands arrive on the s_axis channel; tuser carries the command (0 finds
// a victim in the set, 1 updates the set after an access) and tdata carries
// the set, way, address, hit flag and random chance value. Each command
// returns exactly one transfer on m_axis with the victim way (victim command)
// or the streaming verdict (update command) and the policy selector after it.
// All per-set state (RRPVs, stream score, last address) lives in one row of
// a 2048-entry synchronous RAM. A command is handled as read, compute and
// write-back, and the next command is taken only once the write-back of the
// last one is done, so commands are handled one at a time.
// The finished result sits in an output register, so a new command is taken
// while it waits; only the write-back of the next command holds until the
// receiver drains the register.
// After reset the block sweeps the RAM to its reset contents, one row per
// cycle, over all 2048 rows; s_axis_tready_o stays low until the sweep ends.
// The APB port (threshold at 0x0, stride limit at 0x4) is served at all
// times; the user must write it only while idle, the block does not enforce it.
module drrip_replacement_with_stream_bypass
  import drrip_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Command channel.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: set_index[10:0], way[14:11], address[78:15], hit[79], chance[84:80], zero[87:85]
  input  logic [87:0] s_axis_tdata_i,
  // tuser: cmd[0]
  input  logic        s_axis_tuser_i,
  // Result channel.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: victim_way[3:0], streaming[4], psel_value[14:5], zero[15]
  output logic [15:0] m_axis_tdata_o,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "drrip_replacement_with_stream_bypass_assert.svh"

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_CALC  = 4'b0100,
    ST_WRITE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [SET_W-1:0] clr_cnt_q, clr_cnt_d;

  logic [SCORE_W-1:0] thr_q;
  logic [LIMIT_W-1:0] limit_q;
  logic [PSEL_W-1:0]  psel_q, psel_d;

  // Command registers.
  cmd_e                cmd_q;
  logic [SET_W-1:0]    set_q;
  logic [WAY_W-1:0]    way_q;
  logic [ADDR_W-1:0]   addr_q;
  logic                hit_q;
  logic [CHANCE_W-1:0] chance_q;

  // Compute stage registers.
  row_t row_q;
  logic prev_nz_q;
  logic small_q;

  // Output register.
  logic        out_valid_q;
  logic [15:0] out_data_q;

  logic in_xfer;
  logic out_take;
  logic wb_go;

  // RAM signals.
  logic             ram_we;
  logic [SET_W-1:0] ram_waddr;
  row_t             ram_wdata;
  row_t             ram_rdata;

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_take = out_valid_q && m_axis_tready_i;
  assign wb_go    = (state_q == ST_WRITE) && (!out_valid_q || m_axis_tready_i);

  assign s_axis_tready_o = (state_q == ST_IDLE);

  // Set state memory.
  drrip_ram #(
    .DataW(ROW_W),
    .Depth(SETS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (in_xfer),
    .raddr_i(s_axis_tdata_i[SET_W-1:0]),
    .rdata_o(ram_rdata)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= THR_RESET;
      limit_q <= LIMIT_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_THRESHOLD: thr_q   <= pwdata[SCORE_W-1:0];
        REG_STRIDE:    limit_q <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_THRESHOLD: prdata = {{(32-SCORE_W){1'b0}}, thr_q};
      REG_STRIDE:    prdata = {{(32-LIMIT_W){1'b0}}, limit_q};
      default:       prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // Sequencer: clearing sweep, then read, compute and write-back per command.
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == SET_W'(SETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC:  state_d = ST_WRITE;
      ST_WRITE: begin
        if (wb_go) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // Latch the command on its transfer.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q    <= cmd_e'(s_axis_tuser_i);
      set_q    <= s_axis_tdata_i[10:0];
      way_q    <= s_axis_tdata_i[14:11];
      addr_q   <= s_axis_tdata_i[78:15];
      hit_q    <= s_axis_tdata_i[79];
      chance_q <= s_axis_tdata_i[84:80];
    end
  end

  // Compute stage: address distance and set aging.
  logic [ADDR_W:0]   diff_up;
  logic [ADDR_W-1:0] addr_dist;
  logic              any3, any2, any1;
  logic [1:0]        age_add;
  row_t              row_calc;

  always_comb begin
    diff_up = {1'b0, addr_q} - {1'b0, ram_rdata.hist_addr};
    // A borrow means the stored address is the larger one.
    addr_dist = diff_up[ADDR_W] ? (ram_rdata.hist_addr - addr_q) : diff_up[ADDR_W-1:0];

    any3 = 1'b0;
    any2 = 1'b0;
    any1 = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      any3 = any3 | (ram_rdata.rrpv[w] == 2'd3);
      any2 = any2 | (ram_rdata.rrpv[w] == 2'd2);
      any1 = any1 | (ram_rdata.rrpv[w] == 2'd1);
    end
    // On a victim command, shift every way by the distance from the largest RRPV to far.
    priority if (any3) age_add = 2'd0;
    else if (any2)     age_add = 2'd1;
    else if (any1)     age_add = 2'd2;
    else               age_add = 2'd3;

    row_calc = ram_rdata;
    if (cmd_q == CMD_VICTIM) begin
      for (int w = 0; w < WAYS; w++) begin
        row_calc.rrpv[w] = ram_rdata.rrpv[w] + age_add;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CALC) begin
      row_q     <= row_calc;
      prev_nz_q <= |ram_rdata.hist_addr;
      small_q   <= (addr_dist != '0) &&
                   (addr_dist < {{(ADDR_W-LIMIT_W){1'b0}}, limit_q});
    end
  end

  // Write-back stage: detector, insertion depth, selector and victim.
  logic [SCORE_W-1:0] score_new;
  logic               streaming;
  logic               srrip_leader, brrip_leader;
  logic [1:0]         brrip_depth, depth, rrpv_new;
  logic [WAY_W-1:0]   victim;
  row_t               row_new;
  logic [15:0]        result;

  always_comb begin
    score_new = row_q.score;
    if (prev_nz_q) begin
      if (small_q) begin
        if (row_q.score != SCORE_MAX) score_new = row_q.score + 1'b1;
      end else if (row_q.score != '0) begin
        score_new = row_q.score - 1'b1;
      end
    end
    streaming = (score_new >= thr_q);

    srrip_leader = (set_q < SET_W'(LEADER_SETS / 2));
    brrip_leader = !srrip_leader && (set_q < SET_W'(LEADER_SETS));
    brrip_depth  = (chance_q == '0) ? RRPV_NEAR : RRPV_FAR;
    priority if (srrip_leader)    depth = RRPV_NEAR;
    else if (brrip_leader)        depth = brrip_depth;
    else if (psel_q >= PSEL_RESET) depth = RRPV_NEAR;
    else                          depth = brrip_depth;

    priority if (streaming) rrpv_new = RRPV_FAR;
    else if (hit_q)         rrpv_new = 2'd0;
    else                    rrpv_new = depth;

    // Lowest way holding a far RRPV.
    victim = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row_q.rrpv[w] == RRPV_FAR) victim = WAY_W'(w);
    end

    psel_d  = psel_q;
    row_new = row_q;
    unique case (cmd_q)
      CMD_VICTIM: begin
        result = {1'b0, psel_q, 1'b0, victim};
      end
      CMD_UPDATE: begin
        row_new.hist_addr   = addr_q;
        row_new.score       = score_new;
        row_new.rrpv[way_q] = rrpv_new;
        if (!hit_q) begin
          if (srrip_leader && psel_q != '0) begin
            psel_d = psel_q - 1'b1;
          end else if (brrip_leader && psel_q != PSEL_TOP) begin
            psel_d = psel_q + 1'b1;
          end
        end
        result = {1'b0, psel_d, streaming, {WAY_W{1'b0}}};
      end
      default: result = '0;
    endcase
  end

  // RAM write: clearing sweep or write-back.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = set_q;
    ram_wdata = row_new;
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = ROW_RESET;
    end else if (wb_go) begin
      ram_we = 1'b1;
    end
  end

  // Policy selector.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      psel_q <= PSEL_RESET;
    end else if (wb_go) begin
      psel_q <= psel_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (wb_go) begin
      out_valid_q <= 1'b1;
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wb_go) begin
      out_data_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Checks.
  `DRRIP_ASSERT(a_cmd_flow, in_xfer |=> (state_q == ST_CALC) ##1 (state_q == ST_WRITE),
                "command did not pass through compute and write-back")
  `DRRIP_ASSERT(a_result_src, $rose(m_axis_tvalid_o) |-> $past(state_q == ST_WRITE),
                "result appeared without a write-back")
  `DRRIP_ASSERT(a_psel_src, (psel_q != $past(psel_q)) |-> $past(wb_go && cmd_q == CMD_UPDATE),
                "selector moved outside an update write-back")
  `DRRIP_ASSERT_ALWAYS(a_no_cmd_in_reset, !rst_ni |=> !s_axis_tready_o,
                       "command channel ready during reset")

endmodule

### dv/drrip_replacement_with_stream_bypass_tb.sv
// Self-checking testbench for the DRRIP replacement policy with stream bypass.
module drrip_replacement_with_stream_bypass_tb
  import drrip_pkg::*;
;

  localparam int unsigned STALL_LIMIT = 10000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam logic [1:0] RRPV_HIT = 2'd0;
  localparam int unsigned POOL_SIZE = 8;
  localparam int unsigned SET_POOL [POOL_SIZE] = '{0, 31, 32, 63, 64, 700, 1500, 2047};

  // One command as it travels on the command channel.
  typedef struct {
    cmd_e                cmd;
    logic [SET_W-1:0]    set_idx;
    logic [WAY_W-1:0]    way;
    logic [ADDR_W-1:0]   addr;
    logic                hit;
    logic [CHANCE_W-1:0] chance;
  } access_t;

  // One replacement decision as it travels on the result channel.
  typedef struct {
    logic [WAY_W-1:0]  victim;
    logic              streaming;
    logic [PSEL_W-1:0] psel;
  } decision_t;

  // Flavors of random traffic.
  typedef enum {
    MIX_POOL,
    MIX_SRRIP_MISS,
    MIX_BRRIP_MISS
  } mix_e;

  // Tracks the per-set replacement state and the decisions still owed by the block.
  class drrip_tracker;
    logic [1:0]         rrpv [SETS][WAYS];
    logic [SCORE_W-1:0] score [SETS];
    logic [ADDR_W-1:0]  hist_addr [SETS];
    logic [PSEL_W-1:0]  psel;
    logic [SCORE_W-1:0] threshold;
    logic [LIMIT_W-1:0] stride;
    decision_t          pending_decisions [$];
    int unsigned        mismatches;

    function new();
      for (int unsigned s = 0; s < SETS; s++) begin
        score[s] = '0;
        hist_addr[s] = '0;
        for (int unsigned w = 0; w < WAYS; w++) rrpv[s][w] = RRPV_FAR;
      end
      psel = PSEL_RESET;
      threshold = THR_RESET;
      stride = LIMIT_RESET;
      mismatches = 0;
    endfunction

    function void write_register(logic idx, logic [31:0] value);
      if (idx == REG_THRESHOLD) threshold = value[SCORE_W-1:0];
      else stride = value[LIMIT_W-1:0];
    endfunction

    function logic [31:0] register_value(logic idx);
      if (idx == REG_THRESHOLD) return 32'(threshold);
      return 32'(stride);
    endfunction

    // Apply one accepted command to the state and queue the decision it yields.
    function void note_access(access_t a);
      decision_t         r;
      int unsigned       s;
      logic [1:0]        top;
      logic [1:0]        depth;
      logic [1:0]        brrip_depth;
      logic [ADDR_W-1:0] prev;
      logic [ADDR_W-1:0] addr_dist;
      logic              found;
      logic              srrip_lead;
      logic              brrip_lead;
      s = a.set_idx;
      r.victim = '0;
      r.streaming = 1'b0;
      if (a.cmd == CMD_VICTIM) begin
        // Age the set just enough for some way to reach the far value.
        top = 2'd0;
        for (int unsigned w = 0; w < WAYS; w++) if (rrpv[s][w] > top) top = rrpv[s][w];
        if (top < RRPV_FAR)
          for (int unsigned w = 0; w < WAYS; w++) rrpv[s][w] = rrpv[s][w] + (RRPV_FAR - top);
        found = 1'b0;
        for (int unsigned w = 0; w < WAYS; w++) begin
          if (!found && rrpv[s][w] == RRPV_FAR) begin
            r.victim = WAY_W'(w);
            found = 1'b1;
          end
        end
      end else begin
        // Stream detector: a zero history address leaves the score alone.
        prev = hist_addr[s];
        if (prev != '0) begin
          addr_dist = (a.addr > prev) ? a.addr - prev : prev - a.addr;
          if (addr_dist != '0 && addr_dist < ADDR_W'(stride)) begin
            if (score[s] < SCORE_MAX) score[s]++;
          end else if (score[s] != '0) begin
            score[s]--;
          end
        end
        hist_addr[s] = a.addr;
        r.streaming = (score[s] >= threshold);

        // Insertion depth from set dueling.
        srrip_lead = (s < LEADER_SETS / 2);
        brrip_lead = !srrip_lead && (s < LEADER_SETS);
        brrip_depth = (a.chance == '0) ? RRPV_NEAR : RRPV_FAR;
        if (srrip_lead) depth = RRPV_NEAR;
        else if (brrip_lead) depth = brrip_depth;
        else if (psel >= PSEL_RESET) depth = RRPV_NEAR;
        else depth = brrip_depth;

        if (r.streaming) rrpv[s][a.way] = RRPV_FAR;
        else if (a.hit) rrpv[s][a.way] = RRPV_HIT;
        else rrpv[s][a.way] = depth;

        // Leader misses move the selector, streaming sets included.
        if (!a.hit) begin
          if (srrip_lead && psel != '0) psel--;
          else if (brrip_lead && psel != PSEL_TOP) psel++;
        end
      end
      r.psel = psel;
      pending_decisions.push_back(r);
    endfunction

    task flag_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
    endtask

    // Compare one result transfer with the oldest queued decision.
    task check_decision(logic [15:0] data);
      decision_t want;
      if (pending_decisions.size() == 0) begin
        flag_mismatch($sformatf("result %h with no decision pending", data));
        return;
      end
      want = pending_decisions.pop_front();
      if (data[WAY_W-1:0] !== want.victim)
        flag_mismatch($sformatf("victim_way %0d, want %0d", data[WAY_W-1:0], want.victim));
      if (data[WAY_W] !== want.streaming)
        flag_mismatch($sformatf("streaming %b, want %b", data[WAY_W], want.streaming));
      if (data[WAY_W+1 +: PSEL_W] !== want.psel)
        flag_mismatch($sformatf("psel_value %0d, want %0d", data[WAY_W+1 +: PSEL_W], want.psel));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  // tdata: set_index[10:0], way[14:11], address[78:15], hit[79], chance[84:80], zero[87:85]
  logic [87:0] s_axis_tdata_i = '0;
  // tuser: cmd[0]
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // tdata: victim_way[3:0], streaming[4], psel_value[14:5], zero[15]
  logic [15:0] m_axis_tdata_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  drrip_tracker      tracker = new();
  logic [ADDR_W-1:0] trail [SETS] = '{default: '0};
  bit                calm = 1'b0;
  int unsigned       quiet_cycles = 0;

  drrip_replacement_with_stream_bypass uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #6 clk_i = ~clk_i;

  // End the run when neither channel has moved a transfer for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result receiver with a random stall before each transfer, or none while calm.
  initial begin : result_sink
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 11);
      repeat (stall) begin
        @(negedge clk_i);
        m_axis_tready_i = 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready_i = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      tracker.check_decision(m_axis_tdata_o);
    end
  end

  function automatic access_t build(cmd_e cmd, int unsigned set_idx, int unsigned way,
                                    logic [ADDR_W-1:0] addr, logic hit, int unsigned chance);
    access_t a;
    a.cmd = cmd;
    a.set_idx = SET_W'(set_idx);
    a.way = WAY_W'(way);
    a.addr = addr;
    a.hit = hit;
    a.chance = CHANCE_W'(chance);
    return a;
  endfunction

  // Random command: mostly stride-like addresses per set, with noise mixed in.
  function automatic access_t make_access(mix_e mode);
    access_t           a;
    int unsigned       pick;
    int unsigned       span;
    logic [ADDR_W-1:0] step;
    a.way = WAY_W'($urandom_range(0, WAYS - 1));
    a.chance = ($urandom_range(0, 3) == 0) ? '0 : CHANCE_W'($urandom);
    case (mode)
      MIX_POOL: begin
        a.cmd = ($urandom_range(0, 9) < 3) ? CMD_VICTIM : CMD_UPDATE;
        a.hit = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 6) == 0) a.set_idx = SET_W'($urandom);
        else a.set_idx = SET_W'(SET_POOL[$urandom_range(0, POOL_SIZE - 1)]);
      end
      MIX_SRRIP_MISS: begin
        a.cmd = ($urandom_range(0, 9) == 0) ? CMD_VICTIM : CMD_UPDATE;
        a.hit = ($urandom_range(0, 19) == 0);
        a.set_idx = SET_W'($urandom_range(0, LEADER_SETS / 2 - 1));
      end
      default: begin
        a.cmd = ($urandom_range(0, 9) == 0) ? CMD_VICTIM : CMD_UPDATE;
        a.hit = ($urandom_range(0, 19) == 0);
        a.set_idx = SET_W'($urandom_range(LEADER_SETS / 2, LEADER_SETS - 1));
      end
    endcase
    pick = $urandom_range(0, 9);
    span = 2 * int'(tracker.stride) + 1;
    step = ADDR_W'($urandom_range(0, span));
    if (pick < 6) a.addr = $urandom_range(0, 1) ? trail[a.set_idx] + step : trail[a.set_idx] - step;
    else if (pick == 6) a.addr = trail[a.set_idx];
    else if (pick == 7) a.addr = '0;
    else a.addr = {$urandom, $urandom};
    if (a.cmd == CMD_UPDATE) trail[a.set_idx] = a.addr;
    return a;
  endfunction

  // Drive one command and note it once the block takes it.
  task automatic send_access(access_t a);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid_i = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i = a.cmd;
    s_axis_tdata_i = {3'b000, a.chance, a.hit, a.addr, a.way, a.set_idx};
    do @(posedge clk_i); while (!s_axis_tready_o);
    tracker.note_access(a);
  endtask

  // Stop sending and wait until every queued decision has come back.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (tracker.pending_decisions.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(logic write, logic idx, logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = write;
    paddr = {idx, 2'b00};
    pwdata = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Write a register while the block is idle, then read it back.
  task automatic set_register(logic idx, logic [31:0] value);
    logic [31:0] readback;
    drain();
    apb_access(1'b1, idx, value, readback);
    tracker.write_register(idx, value);
    apb_access(1'b0, idx, '0, readback);
    if (readback !== tracker.register_value(idx))
      tracker.flag_mismatch($sformatf("register %0d reads %h, want %h", idx, readback,
                                      tracker.register_value(idx)));
  endtask

  task automatic run_random(mix_e mode, int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 49) == 0) drain();
      send_access(make_access(mode));
    end
    calm = 1'b0;
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed commands with a low threshold so that streaming shows up quickly.
    set_register(REG_THRESHOLD, 32'd2);
    set_register(REG_STRIDE, 32'd256);
    send_access(build(CMD_VICTIM, 0, 0, '0, 1'b0, 0));
    send_access(build(CMD_UPDATE, 40, 15, '0, 1'b0, 0));
    send_access(build(CMD_UPDATE, 40, 0, 64'h100, 1'b0, 31));
    send_access(build(CMD_UPDATE, 40, 1, 64'h180, 1'b0, 1));
    send_access(build(CMD_VICTIM, 40, 0, '0, 1'b0, 0));
    send_access(build(CMD_UPDATE, 5, 3, 64'd1000, 1'b1, 7));
    send_access(build(CMD_UPDATE, 5, 4, 64'd1010, 1'b0, 7));
    send_access(build(CMD_UPDATE, 5, 5, 64'd1005, 1'b0, 7));
    // Same address again: zero distance lowers the score.
    send_access(build(CMD_UPDATE, 5, 3, 64'd1005, 1'b1, 7));
    send_access(build(CMD_VICTIM, 5, 0, '0, 1'b0, 0));
    // Address extremes, including a return to the no-history value.
    send_access(build(CMD_UPDATE, 2047, 15, '1, 1'b0, 31));
    send_access(build(CMD_UPDATE, 2047, 14, '0, 1'b0, 0));
    send_access(build(CMD_UPDATE, 2047, 13, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 0));
    send_access(build(CMD_UPDATE, 2047, 12, '1, 1'b0, 0));
    // Leader and follower insertion around the selector midpoint.
    send_access(build(CMD_UPDATE, 31, 0, 64'h8000_0000_0000_0000, 1'b0, 0));
    send_access(build(CMD_UPDATE, 63, 7, 64'h4000, 1'b0, 31));
    send_access(build(CMD_UPDATE, 32, 8, 64'h5000, 1'b1, 0));
    send_access(build(CMD_UPDATE, 64, 9, 64'h6000, 1'b0, 0));
    send_access(build(CMD_UPDATE, 31, 1, 64'h9000, 1'b0, 3));
    send_access(build(CMD_UPDATE, 64, 10, 64'h6800, 1'b0, 5));
    send_access(build(CMD_UPDATE, 64, 11, 64'h7000, 1'b0, 0));
    send_access(build(CMD_VICTIM, 64, 0, '0, 1'b0, 0));
    // Distances just under and exactly at the stride limit.
    send_access(build(CMD_UPDATE, 100, 2, 64'h1000, 1'b1, 9));
    send_access(build(CMD_UPDATE, 100, 3, 64'h10FF, 1'b0, 9));
    send_access(build(CMD_UPDATE, 100, 4, 64'h11FF, 1'b0, 9));
    send_access(build(CMD_VICTIM, 2047, 0, '0, 1'b0, 0));

    // Random traffic under the default settings.
    set_register(REG_THRESHOLD, 32'(THR_RESET));
    set_register(REG_STRIDE, 32'(LIMIT_RESET));
    run_random(MIX_POOL, 120);

    // Drive the selector down with SRRIP leader misses and a stride limit of 65536.
    set_register(REG_THRESHOLD, 32'd15);
    set_register(REG_STRIDE, 32'd65536);
    run_random(MIX_SRRIP_MISS, 130);

    // Then up with BRRIP leader misses, every set streaming and no small strides.
    set_register(REG_THRESHOLD, 32'd0);
    set_register(REG_STRIDE, 32'd1);
    run_random(MIX_BRRIP_MISS, 130);

    set_register(REG_THRESHOLD, 32'd4);
    set_register(REG_STRIDE, 32'd4096);
    run_random(MIX_POOL, 100);

    drain();
    if (tracker.mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

### drrip_replacement_with_stream_bypass.f
+incdir+src
src/drrip_pkg.sv
src/drrip_ram.sv
src/drrip_replacement_with_stream_bypass.sv
dv/drrip_replacement_with_stream_bypass_tb.sv
